// ===== rtl/core/hfec_pkg.sv =====
`timescale 1ns / 1ps

package hfec_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int WORD_W        = 64;
  localparam int LEN_W         = 7;
  localparam int SYN_W         = 7;
  localparam int POS_W         = 6;
  // Count of power-of-two positions in 1..MAX_CODE_BITS.
  localparam int NUM_PARITY    = $clog2(MAX_CODE_BITS + 1);
  localparam int MAX_DATA_BITS = MAX_CODE_BITS - NUM_PARITY;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  // Zero-based word index of each data bit; entries past the last data bit are unused.
  typedef logic [(1 << POS_W)-1:0][POS_W-1:0] didx_tab_t;
  // Per syndrome bit, the word bits whose 1-based position has that bit set.
  typedef logic [SYN_W-1:0][WORD_W-1:0] col_tab_t;

  typedef struct packed {
    logic             op;
    logic             too_long;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] res_len;
    logic [WORD_W-1:0] code;
  } hfec_word_t;

  typedef struct packed {
    hfec_word_t       word;
    logic [SYN_W-1:0] syn;
  } hfec_synd_t;

  function automatic didx_tab_t build_didx();
    didx_tab_t tab;
    int        cnt;
    tab = '0;
    cnt = 0;
    for (int pos = 1; pos <= MAX_CODE_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        tab[cnt] = POS_W'(pos - 1);
        cnt++;
      end
    end
    return tab;
  endfunction

  function automatic col_tab_t build_cols();
    col_tab_t tab;
    tab = '0;
    for (int b = 0; b < SYN_W; b++) begin
      for (int i = 0; i < WORD_W; i++) begin
        tab[b][i] = (((i + 1) >> b) & 1) != 0;
      end
    end
    return tab;
  endfunction

  localparam didx_tab_t DIDX_TAB = build_didx();
  localparam col_tab_t  COL_TAB  = build_cols();

  // Number of data bits carried by a code frame of the given length.
  function automatic logic [LEN_W-1:0] data_len_of(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] cnt;
    cnt = len;
    for (int k = 0; k < NUM_PARITY; k++) begin
      if (int'(len) >= (1 << k)) begin
        cnt = cnt - LEN_W'(1);
      end
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/core/hfec_prep.sv =====
`timescale 1ns / 1ps

module hfec_prep
  import hfec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              op,
  input  logic [WORD_W-1:0] frame_bits,
  input  logic [LEN_W-1:0]  frame_length,
  output logic              out_valid,
  output hfec_word_t        out_word
);

  logic [WORD_W-1:0] bits_m;
  logic [WORD_W-1:0] scatter;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  enc_len;
  hfec_word_t        word_nxt;
  hfec_word_t        word_r;
  logic              valid_r;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      bits_m[i] = frame_bits[i] & (i < int'(frame_length));
    end

    // Data bits go to the positions that are not powers of two.
    scatter = '0;
    for (int j = 0; j < MAX_DATA_BITS; j++) begin
      scatter[DIDX_TAB[j]] = bits_m[j];
    end

    len_m1  = frame_length - LEN_W'(1);
    enc_len = (frame_length == '0) ? '0
            : {1'b0, DIDX_TAB[len_m1[POS_W-1:0]]} + LEN_W'(1);

    word_nxt.op  = op;
    word_nxt.len = frame_length;
    if (op == OP_ENCODE) begin
      word_nxt.too_long = int'(frame_length) > MAX_DATA_BITS;
      word_nxt.code     = scatter;
      word_nxt.res_len  = enc_len;
    end else begin
      word_nxt.too_long = int'(frame_length) > MAX_CODE_BITS;
      word_nxt.code     = bits_m;
      word_nxt.res_len  = data_len_of(frame_length);
    end
    if (word_nxt.too_long) begin
      word_nxt.res_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/hfec_synd.sv =====
`timescale 1ns / 1ps

module hfec_synd
  import hfec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  hfec_word_t in_word,
  output logic       out_valid,
  output hfec_synd_t out_synd
);

  hfec_synd_t synd_nxt;
  hfec_synd_t synd_r;
  logic       valid_r;

  // The syndrome is the XOR of the positions of all set bits. On an encode
  // word, syndrome bit b is also the parity for position 2**b.
  always_comb begin
    synd_nxt.word = in_word;
    for (int b = 0; b < SYN_W; b++) begin
      synd_nxt.syn[b] = ^(in_word.code & COL_TAB[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    synd_r <= synd_nxt;
  end

  assign out_valid = valid_r;
  assign out_synd  = synd_r;

endmodule

// ===== rtl/core/hfec_fix.sv =====
`timescale 1ns / 1ps

module hfec_fix
  import hfec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  hfec_synd_t        in_synd,
  output logic              out_valid,
  output logic [WORD_W-1:0] result_bits,
  output logic [LEN_W-1:0]  result_length,
  output status_t           status
);

  logic [WORD_W-1:0] fixed;
  logic [SYN_W-1:0]  syn_m1;
  logic [WORD_W-1:0] res_nxt;
  logic [LEN_W-1:0]  len_nxt;
  status_t           status_nxt;
  logic              valid_r;
  logic [WORD_W-1:0] res_r;
  logic [LEN_W-1:0]  len_r;
  status_t           status_r;

  always_comb begin
    fixed      = in_synd.word.code;
    syn_m1     = in_synd.syn - SYN_W'(1);
    status_nxt = ST_CLEAN;
    res_nxt    = '0;
    len_nxt    = in_synd.word.res_len;

    if (in_synd.word.op == OP_ENCODE) begin
      res_nxt = in_synd.word.code;
      for (int b = 0; b < NUM_PARITY; b++) begin
        res_nxt[POS_W'((1 << b) - 1)] = in_synd.syn[b];
      end
    end else begin
      if (in_synd.syn != '0) begin
        if (in_synd.syn <= in_synd.word.len) begin
          fixed[syn_m1[POS_W-1:0]] = ~fixed[syn_m1[POS_W-1:0]];
          status_nxt = ST_CORRECTED;
        end else begin
          status_nxt = ST_BEYOND;
        end
      end
      // Positions past the frame are already zero, so no length mask is needed.
      for (int j = 0; j < MAX_DATA_BITS; j++) begin
        res_nxt[j] = fixed[DIDX_TAB[j]];
      end
    end

    if (in_synd.word.too_long) begin
      res_nxt    = '0;
      len_nxt    = '0;
      status_nxt = ST_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
  end

  assign out_valid     = valid_r;
  assign result_bits   = res_r;
  assign result_length = len_r;
  assign status        = status_r;

endmodule

// ===== rtl/core/hamming_frame_encode_correct.sv =====
`timescale 1ns / 1ps

// Hamming single-error-correcting frame codec.
// Input channel: a word is taken at each rising edge with start high and busy
// low. in_op selects encode (data frame in, code word out) or decode (code
// frame in, corrected data out); in_frame_length gives the valid bits of
// in_frame_bits, bit i being position i+1.
// Result channel: out_valid is high for exactly one cycle per word, with
// out_result_bits, out_result_length and out_status on the same cycle.
// Each word passes through registered stages in order: one places or masks the
// bits, one forms the syndrome XOR trees, and one applies parity or the
// correction and strips the parity positions.
// Throughput is one word per cycle; busy stays low, so start may be held
// high every cycle.
// Synchronous reset clears the valid pipeline; words in flight are dropped.
// The receiver cannot stall, and none is needed since every result leaves
// the output register on the cycle after it is formed.
module hamming_frame_encode_correct
  import hfec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [WORD_W-1:0] in_frame_bits,
  input  logic [LEN_W-1:0]  in_frame_length,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_result_bits,
  output logic [LEN_W-1:0]  out_result_length,
  output logic [1:0]        out_status
);

  logic       prep_valid;
  hfec_word_t prep_word;
  logic       synd_valid;
  hfec_synd_t synd_word;
  status_t    fix_status;

  // Every stage advances every cycle, so a new word is always welcome.
  assign busy = 1'b0;

  hfec_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start & ~busy),
    .op           (in_op),
    .frame_bits   (in_frame_bits),
    .frame_length (in_frame_length),
    .out_valid    (prep_valid),
    .out_word     (prep_word)
  );

  hfec_synd u_synd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_word   (prep_word),
    .out_valid (synd_valid),
    .out_synd  (synd_word)
  );

  hfec_fix u_fix (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (synd_valid),
    .in_synd       (synd_word),
    .out_valid     (out_valid),
    .result_bits   (out_result_bits),
    .result_length (out_result_length),
    .status        (fix_status)
  );

  assign out_status = fix_status;

endmodule
